FILE: rtl/core/wspd_pkg.sv
// Package for the weather service packet decoder.
// Holds the header bit positions, the conversion constants and the packet type
// shared by the byte gatherer and the result converter. Depends on nothing.
package wspd_pkg;

    // Header bit positions.
    localparam int HdrGatewayBit = 7;
    localparam int HdrTempBit    = 6;
    localparam int HdrWindBit    = 5;
    localparam int HdrHumBit     = 4;
    localparam int HdrPressBit   = 3;
    localparam int HdrExtBit     = 0;

    // Field-complete flag positions.
    localparam int FlagTemp  = 0;
    localparam int FlagWind  = 1;
    localparam int FlagHum   = 2;
    localparam int FlagPress = 3;

    localparam int CoordBytes = 6;
    localparam int WindBytes  = 3;
    localparam int PressBytes = 2;

    // Heading is floor(b * 5760 / 255) = floor(b * 384 / 17). It is computed as
    // (b * 384 * ceil(2^24 / 17)) >> 24, which is exact for every byte value.
    localparam logic [28:0] HeadingMul   = 29'd378968064;
    localparam int          HeadingShift = 24;
    localparam int          HeadingWidth = 13;

    localparam logic [9:0]  HumidityMax  = 10'd1000;
    localparam logic [16:0] PressureBase = 17'd43000;

    typedef struct packed {
        logic        gateway;
        logic [3:0]  flags;
        logic [7:0]  temp;
        logic [23:0] wind;
        logic [7:0]  hum;
        logic [15:0] press;
        logic [47:0] coord;
    } packet_t;

    // Speed and gusts: low seven bits, times five when bit 7 is set.
    function automatic logic [9:0] speed_units(logic [7:0] b);
        logic [9:0] low;
        low = {3'b000, b[6:0]};
        return b[7] ? ((low << 2) + low) : low;
    endfunction

endpackage

FILE: rtl/core/wspd_gather.sv
// Byte gatherer for the weather service packet decoder.
// Tracks the byte position, sorts each byte into its field and hands a finished
// packet to the converter. Depends on wspd_pkg.
module wspd_gather
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_packet,
    output logic                 pkt_valid,
    input  logic                 pkt_take,
    output wspd_pkg::packet_t    pkt
);

    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [47:0] coord_reg, coord_next;
    logic [7:0]  temp_reg, temp_next;
    logic [23:0] wind_reg, wind_next;
    logic [7:0]  hum_reg, hum_next;
    logic [15:0] press_reg, press_next;
    logic [3:0]  flags_reg, flags_next;
    logic        pkt_valid_reg, pkt_valid_next;
    wspd_pkg::packet_t pkt_reg, pkt_next;

    logic        accept;
    logic [5:0]  pos6;
    logic [5:0]  coord_lo, temp_lo, wind_lo, hum_lo, press_lo;
    logic [5:0]  coord_diff, wind_diff, press_diff;
    logic        coord_hit, temp_hit, wind_hit, hum_hit, press_hit;

    assign item_stall = pkt_valid_reg && !pkt_take;
    assign accept     = item_valid && !item_stall;
    assign pkt_valid  = pkt_valid_reg;
    assign pkt        = pkt_reg;

    // Start position of each region, given which fields the header announces.
    always_comb
    begin
        pos6     = {1'b0, pos_reg};
        coord_lo = 6'd1 + {5'b0, hdr_reg[wspd_pkg::HdrExtBit]};
        temp_lo  = 6'd7 + {5'b0, hdr_reg[wspd_pkg::HdrExtBit]};
        wind_lo  = temp_lo + {5'b0, hdr_reg[wspd_pkg::HdrTempBit]};
        hum_lo   = wind_lo + (hdr_reg[wspd_pkg::HdrWindBit] ? 6'd3 : 6'd0);
        press_lo = hum_lo + {5'b0, hdr_reg[wspd_pkg::HdrHumBit]};

        coord_diff = pos6 - coord_lo;
        wind_diff  = pos6 - wind_lo;
        press_diff = pos6 - press_lo;

        coord_hit = (pos_reg != 5'd0) && (pos6 >= coord_lo) && (coord_diff < 6'd6);
        temp_hit  = hdr_reg[wspd_pkg::HdrTempBit] && (pos6 == temp_lo);
        wind_hit  = hdr_reg[wspd_pkg::HdrWindBit] && (pos6 >= wind_lo)
                    && (wind_diff < 6'd3);
        hum_hit   = hdr_reg[wspd_pkg::HdrHumBit] && (pos6 == hum_lo);
        press_hit = hdr_reg[wspd_pkg::HdrPressBit] && (pos6 >= press_lo)
                    && (press_diff < 6'd2);
    end

    always_comb
    begin
        hdr_next   = (pos_reg == 5'd0) ? data_byte : hdr_reg;
        coord_next = coord_reg;
        temp_next  = temp_reg;
        wind_next  = wind_reg;
        hum_next   = hum_reg;
        press_next = press_reg;
        flags_next = flags_reg;
        pos_next   = (&pos_reg) ? pos_reg : pos_reg + 5'd1;

        for (int i = 0; i < wspd_pkg::CoordBytes; i++)
        begin
            if (coord_hit && coord_diff[2:0] == 3'(i))
            begin
                coord_next[8*i +: 8] = coord_reg[8*i +: 8] | data_byte;
            end
        end
        if (temp_hit)
        begin
            temp_next                    = data_byte;
            flags_next[wspd_pkg::FlagTemp] = 1'b1;
        end
        for (int i = 0; i < wspd_pkg::WindBytes; i++)
        begin
            if (wind_hit && wind_diff[1:0] == 2'(i))
            begin
                wind_next[8*i +: 8] = wind_reg[8*i +: 8] | data_byte;
            end
        end
        if (wind_hit && wind_diff[1:0] == 2'(wspd_pkg::WindBytes - 1))
        begin
            flags_next[wspd_pkg::FlagWind] = 1'b1;
        end
        if (hum_hit)
        begin
            hum_next                      = data_byte;
            flags_next[wspd_pkg::FlagHum] = 1'b1;
        end
        for (int i = 0; i < wspd_pkg::PressBytes; i++)
        begin
            if (press_hit && press_diff[0] == 1'(i))
            begin
                press_next[8*i +: 8] = press_reg[8*i +: 8] | data_byte;
            end
        end
        if (press_hit && press_diff[0] == 1'(wspd_pkg::PressBytes - 1))
        begin
            flags_next[wspd_pkg::FlagPress] = 1'b1;
        end

        pkt_next.gateway = hdr_next[wspd_pkg::HdrGatewayBit];
        pkt_next.flags   = flags_next;
        pkt_next.temp    = temp_next;
        pkt_next.wind    = wind_next;
        pkt_next.hum     = hum_next;
        pkt_next.press   = press_next;
        pkt_next.coord   = coord_next;

        if (accept && end_of_packet)
        begin
            pkt_valid_next = 1'b1;
        end
        else if (pkt_take)
        begin
            pkt_valid_next = 1'b0;
        end
        else
        begin
            pkt_valid_next = pkt_valid_reg;
        end
    end

    // The last byte of a packet returns the gathering state to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hdr_reg       <= '0;
            coord_reg     <= '0;
            temp_reg      <= '0;
            wind_reg      <= '0;
            hum_reg       <= '0;
            press_reg     <= '0;
            flags_reg     <= '0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            pkt_valid_reg <= pkt_valid_next;
            if (accept)
            begin
                if (end_of_packet)
                begin
                    pos_reg   <= '0;
                    hdr_reg   <= '0;
                    coord_reg <= '0;
                    temp_reg  <= '0;
                    wind_reg  <= '0;
                    hum_reg   <= '0;
                    press_reg <= '0;
                    flags_reg <= '0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    hdr_reg   <= hdr_next;
                    coord_reg <= coord_next;
                    temp_reg  <= temp_next;
                    wind_reg  <= wind_next;
                    hum_reg   <= hum_next;
                    press_reg <= press_next;
                    flags_reg <= flags_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_packet)
        begin
            pkt_reg <= pkt_next;
        end
    end

endmodule

FILE: rtl/core/wspd_convert.sv
// Result converter for the weather service packet decoder.
// Turns a gathered packet into fixed-point fields and holds them in the result
// register. Depends on wspd_pkg.
module wspd_convert
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pkt_valid,
    output logic                 pkt_take,
    input  wspd_pkg::packet_t    pkt,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 from_gateway,
    output logic                 temperature_valid,
    output logic signed [7:0]    temperature_half_deg,
    output logic                 wind_valid,
    output logic [12:0]          wind_direction,
    output logic [9:0]           wind_velocity,
    output logic [9:0]           gust_velocity,
    output logic                 humidity_valid,
    output logic [9:0]           humidity_permille,
    output logic                 pressure_valid,
    output logic [16:0]          pressure_pa,
    output logic [47:0]          coordinates_raw
);

    logic        result_valid_reg, result_valid_next;
    logic        gateway_reg, gateway_next;
    logic [3:0]  flags_reg, flags_next;
    logic [7:0]  temp_reg, temp_next;
    logic [12:0] heading_reg, heading_next;
    logic [9:0]  speed_reg, speed_next;
    logic [9:0]  gusts_reg, gusts_next;
    logic [9:0]  hum_reg, hum_next;
    logic [16:0] press_reg, press_next;
    logic [47:0] coord_reg, coord_next;

    logic        load;
    logic [36:0] heading_prod;
    logic [9:0]  hum_x4;

    assign load     = pkt_valid && (!result_valid_reg || !result_stall);
    assign pkt_take = load;

    always_comb
    begin
        heading_prod = 37'(pkt.wind[7:0]) * 37'(wspd_pkg::HeadingMul);
        hum_x4       = {pkt.hum, 2'b00};

        gateway_next = pkt.gateway;
        flags_next   = pkt.flags;
        coord_next   = pkt.coord;
        temp_next    = '0;
        heading_next = '0;
        speed_next   = '0;
        gusts_next   = '0;
        hum_next     = '0;
        press_next   = '0;

        if (pkt.flags[wspd_pkg::FlagTemp])
        begin
            temp_next = pkt.temp;
        end
        if (pkt.flags[wspd_pkg::FlagWind])
        begin
            heading_next = heading_prod[wspd_pkg::HeadingShift +: wspd_pkg::HeadingWidth];
            speed_next   = wspd_pkg::speed_units(pkt.wind[15:8]);
            gusts_next   = wspd_pkg::speed_units(pkt.wind[23:16]);
        end
        if (pkt.flags[wspd_pkg::FlagHum])
        begin
            hum_next = (hum_x4 > wspd_pkg::HumidityMax) ? wspd_pkg::HumidityMax : hum_x4;
        end
        if (pkt.flags[wspd_pkg::FlagPress])
        begin
            press_next = 17'(pkt.press) + wspd_pkg::PressureBase;
        end

        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            gateway_reg <= gateway_next;
            flags_reg   <= flags_next;
            temp_reg    <= temp_next;
            heading_reg <= heading_next;
            speed_reg   <= speed_next;
            gusts_reg   <= gusts_next;
            hum_reg     <= hum_next;
            press_reg   <= press_next;
            coord_reg   <= coord_next;
        end
    end

    assign result_valid         = result_valid_reg;
    assign from_gateway         = gateway_reg;
    assign temperature_valid    = flags_reg[wspd_pkg::FlagTemp];
    assign temperature_half_deg = signed'(temp_reg);
    assign wind_valid           = flags_reg[wspd_pkg::FlagWind];
    assign wind_direction       = heading_reg;
    assign wind_velocity        = speed_reg;
    assign gust_velocity        = gusts_reg;
    assign humidity_valid       = flags_reg[wspd_pkg::FlagHum];
    assign humidity_permille    = hum_reg;
    assign pressure_valid       = flags_reg[wspd_pkg::FlagPress];
    assign pressure_pa          = press_reg;
    assign coordinates_raw      = coord_reg;

endmodule

FILE: rtl/core/weather_service_packet_decoder_unit.sv
// Weather service packet decoder: one payload byte per cycle, one result per packet.
// Throughput is one byte every cycle; a byte is stalled only while a finished
// packet waits in the packet register behind a stalled result register.
// When the last byte of a packet is accepted the packet register loads it, and the result
// register takes it from there once that register is empty or its result is not stalled.
// Reset is asynchronous, active low, and clears the byte position, the gathered
// fields and both valid flags.
module weather_service_packet_decoder_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_packet,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 from_gateway,
    output logic                 temperature_valid,
    output logic signed [7:0]    temperature_half_deg,
    output logic                 wind_valid,
    output logic [12:0]          wind_direction,
    output logic [9:0]           wind_velocity,
    output logic [9:0]           gust_velocity,
    output logic                 humidity_valid,
    output logic [9:0]           humidity_permille,
    output logic                 pressure_valid,
    output logic [16:0]          pressure_pa,
    output logic [47:0]          coordinates_raw
);

    logic              pkt_valid;
    logic              pkt_take;
    wspd_pkg::packet_t pkt;

    wspd_gather u_gather
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .pkt_valid     (pkt_valid),
        .pkt_take      (pkt_take),
        .pkt           (pkt)
    );

    wspd_convert u_convert
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .pkt_valid            (pkt_valid),
        .pkt_take             (pkt_take),
        .pkt                  (pkt),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .from_gateway         (from_gateway),
        .temperature_valid    (temperature_valid),
        .temperature_half_deg (temperature_half_deg),
        .wind_valid           (wind_valid),
        .wind_direction       (wind_direction),
        .wind_velocity        (wind_velocity),
        .gust_velocity        (gust_velocity),
        .humidity_valid       (humidity_valid),
        .humidity_permille    (humidity_permille),
        .pressure_valid       (pressure_valid),
        .pressure_pa          (pressure_pa),
        .coordinates_raw      (coordinates_raw)
    );

endmodule

FILE: rtl/core/wspd_checker.sv
// Port-level checker for the weather service packet decoder.
// Watches the top level's result channel and is attached by the bind below.
// Depends only on the ports of weather_service_packet_decoder_unit.
module wspd_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_stall,
    input logic                 temperature_valid,
    input logic signed [7:0]    temperature_half_deg,
    input logic                 wind_valid,
    input logic [12:0]          wind_direction,
    input logic [9:0]           wind_velocity,
    input logic [9:0]           gust_velocity,
    input logic                 humidity_valid,
    input logic [9:0]           humidity_permille,
    input logic                 pressure_valid,
    input logic [16:0]          pressure_pa
);

    // A stalled result transaction must stay offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // Absent fields read as zero.
    a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !temperature_valid |-> temperature_half_deg == 8'sd0)
        else $error("temperature nonzero while invalid");

    a_wind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (wind_valid ? (wind_direction <= 13'd5760)
            : (wind_direction == 13'd0 && wind_velocity == 10'd0
               && gust_velocity == 10'd0)))
        else $error("wind fields out of range");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (humidity_valid ? (humidity_permille <= 10'd1000)
            : (humidity_permille == 10'd0)))
        else $error("humidity out of range");

    a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pressure_valid ? (pressure_pa >= 17'd43000)
            : (pressure_pa == 17'd0)))
        else $error("pressure out of range");

endmodule

bind weather_service_packet_decoder_unit wspd_checker u_wspd_checker
(
    .clk                  (clk),
    .rst_n                (rst_n),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .temperature_valid    (temperature_valid),
    .temperature_half_deg (temperature_half_deg),
    .wind_valid           (wind_valid),
    .wind_direction       (wind_direction),
    .wind_velocity        (wind_velocity),
    .gust_velocity        (gust_velocity),
    .humidity_valid       (humidity_valid),
    .humidity_permille    (humidity_permille),
    .pressure_valid       (pressure_valid),
    .pressure_pa          (pressure_pa)
);
